@@ rtl/baro_pkg.sv @@
`timescale 1ns / 1ps

package baro_pkg;

  localparam int unsigned STEP_W = 5;

  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  localparam logic [1:0] REG_TEMP_TRIM = 2'd0;
  localparam logic [1:0] REG_PRES_LOW  = 2'd1;
  localparam logic [1:0] REG_PRES_HIGH = 2'd2;

  localparam logic signed [20:0] T_RESET = 21'sd3840;

  localparam logic signed [63:0] RND_TEMP = 64'sd1 <<< 39;
  localparam logic signed [63:0] RND_PRES = 64'sd1 <<< 15;

  localparam logic [STEP_W-1:0] LAST_PRES_STEP = 5'd27;

  // Operand A sources of the shared multiplier.
  typedef enum logic [2:0] {
    A_X   = 3'd0,
    A_T   = 3'd1,
    A_T2  = 3'd2,
    A_T3S = 3'd3,
    A_R2S = 3'd4,
    A_R3  = 3'd5,
    A_U   = 3'd6,
    A_S   = 3'd7
  } a_sel_e;

  // Operand B sources: sample terms and trim coefficients.
  typedef enum logic [3:0] {
    B_X   = 4'd0,
    B_T   = 4'd1,
    B_T2C = 4'd2,
    B_T3C = 4'd3,
    B_C2M = 4'd4,
    B_C3  = 4'd5,
    B_C4  = 4'd6,
    B_C6  = 4'd7,
    B_C7  = 4'd8,
    B_C8  = 4'd9,
    B_C9  = 4'd10,
    B_C10 = 4'd11,
    B_C11 = 4'd12
  } b_sel_e;

  // A wide A operand is multiplied in two passes: low 31 bits, then the rest.
  typedef enum logic [1:0] {
    MUL_NONE = 2'd0,
    MUL_FULL = 2'd1,
    MUL_LO   = 2'd2,
    MUL_HI   = 2'd3
  } mul_e;

  typedef enum logic [3:0] {
    WB_NONE    = 4'd0,
    WB_ACC_SET = 4'd1,
    WB_ACC_ADD = 4'd2,
    WB_S_ADD   = 4'd3,
    WB_T2      = 4'd4,
    WB_T3S     = 4'd5,
    WB_R2S     = 4'd6,
    WB_R3      = 4'd7,
    WB_U       = 4'd8
  } wb_e;

  typedef struct packed {
    a_sel_e      a_sel;
    b_sel_e      b_sel;
    mul_e        mul;
    wb_e         wb;
    logic [4:0]  shl;
    logic [5:0]  shr;
    logic        load;
    logic        fin;
  } cmd_t;

  function automatic cmd_t mk(input a_sel_e a, input b_sel_e b, input mul_e m, input wb_e w,
                              input logic [4:0] shl, input logic [5:0] shr,
                              input logic fin);
    cmd_t c;
    c.a_sel = a;
    c.b_sel = b;
    c.mul   = m;
    c.wb    = w;
    c.shl   = shl;
    c.shr   = shr;
    c.load  = 1'b0;
    c.fin   = fin;
    return c;
  endfunction

  // Microprogram. A write-back in a step uses the product formed by the step before.
  function automatic cmd_t prog_cmd(input logic kind, input logic [STEP_W-1:0] step);
    cmd_t c;
    c = mk(A_X, B_X, MUL_NONE, WB_NONE, 5'd0, 6'd0, 1'b1);
    if (kind == KIND_TEMP) begin
      case (step)
        5'd0: c = mk(A_X, B_T2C, MUL_FULL, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd1: c = mk(A_X, B_X, MUL_FULL, WB_ACC_SET, 5'd18, 6'd0, 1'b0);
        5'd2: c = mk(A_X, B_X, MUL_NONE, WB_U, 5'd0, 6'd0, 1'b0);
        5'd3: c = mk(A_U, B_T3C, MUL_LO, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd4: c = mk(A_U, B_T3C, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd5: c = mk(A_X, B_X, MUL_NONE, WB_ACC_ADD, 5'd0, 6'd0, 1'b0);
        default: c = mk(A_X, B_X, MUL_NONE, WB_NONE, 5'd0, 6'd0, 1'b1);
      endcase
    end else begin
      case (step)
        5'd0:  c = mk(A_T, B_T, MUL_FULL, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd1:  c = mk(A_X, B_X, MUL_FULL, WB_T2, 5'd0, 6'd0, 1'b0);
        5'd2:  c = mk(A_T2, B_T, MUL_LO, WB_R2S, 5'd0, 6'd16, 1'b0);
        5'd3:  c = mk(A_T2, B_T, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd4:  c = mk(A_R2S, B_X, MUL_LO, WB_T3S, 5'd0, 6'd8, 1'b0);
        5'd5:  c = mk(A_R2S, B_X, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd6:  c = mk(A_T, B_C6, MUL_FULL, WB_R3, 5'd0, 6'd0, 1'b0);
        5'd7:  c = mk(A_T, B_C2M, MUL_FULL, WB_ACC_ADD, 5'd2, 6'd0, 1'b0);
        5'd8:  c = mk(A_T2, B_C7, MUL_LO, WB_S_ADD, 5'd0, 6'd7, 1'b0);
        5'd9:  c = mk(A_T2, B_C7, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd10: c = mk(A_T3S, B_C8, MUL_LO, WB_ACC_ADD, 5'd0, 6'd8, 1'b0);
        5'd11: c = mk(A_T3S, B_C8, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd12: c = mk(A_T2, B_C3, MUL_LO, WB_ACC_ADD, 5'd0, 6'd15, 1'b0);
        5'd13: c = mk(A_T2, B_C3, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd14: c = mk(A_T3S, B_C4, MUL_LO, WB_S_ADD, 5'd0, 6'd18, 1'b0);
        5'd15: c = mk(A_T3S, B_C4, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd16: c = mk(A_R2S, B_C9, MUL_LO, WB_S_ADD, 5'd0, 6'd23, 1'b0);
        5'd17: c = mk(A_R2S, B_C9, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd18: c = mk(A_R2S, B_C10, MUL_LO, WB_ACC_ADD, 5'd0, 6'd16, 1'b0);
        5'd19: c = mk(A_R2S, B_C10, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd20: c = mk(A_S, B_X, MUL_LO, WB_U, 5'd0, 6'd0, 1'b0);
        5'd21: c = mk(A_S, B_X, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd22: c = mk(A_U, B_T, MUL_LO, WB_ACC_ADD, 5'd0, 6'd14, 1'b0);
        5'd23: c = mk(A_U, B_T, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd24: c = mk(A_R3, B_C11, MUL_LO, WB_ACC_ADD, 5'd0, 6'd24, 1'b0);
        5'd25: c = mk(A_R3, B_C11, MUL_HI, WB_NONE, 5'd0, 6'd0, 1'b0);
        5'd26: c = mk(A_X, B_X, MUL_NONE, WB_ACC_ADD, 5'd0, 6'd33, 1'b0);
        default: c = mk(A_X, B_X, MUL_NONE, WB_NONE, 5'd0, 6'd0, 1'b1);
      endcase
    end
    return c;
  endfunction

endpackage

@@ rtl/baro_dp.sv @@
`timescale 1ns / 1ps

module baro_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  baro_pkg::cmd_t    cmd_i,
  input  logic              req_type_i,
  input  logic [23:0]       raw_sample_i,
  input  logic [39:0]       temp_trim_i,
  input  logic [63:0]       pres_low_i,
  input  logic [63:0]       pres_high_i,
  output logic              kind_o,
  output logic              result_kind_o,
  output logic signed [31:0] value_o,
  output logic              saturated_o
);

  logic kind_q;
  logic signed [24:0] x_q;
  logic signed [20:0] t_q;
  logic signed [39:0] t2_q;
  logic signed [47:0] t3s_q;
  logic signed [32:0] r2s_q;
  logic signed [56:0] r3_q;
  logic signed [49:0] u_q;
  logic signed [39:0] s_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] prod_q, prod_d;

  logic [15:0] c_t1, c_t2, c5, c6;
  logic signed [7:0] c_t3, c3, c4, c7, c8, c10, c11;
  logic signed [15:0] c1, c2, c9;
  logic signed [17:0] c1m, c2m;

  assign c_t1 = temp_trim_i[15:0];
  assign c_t2 = temp_trim_i[31:16];
  assign c_t3 = temp_trim_i[39:32];
  assign c1   = pres_low_i[15:0];
  assign c2   = pres_low_i[31:16];
  assign c3   = pres_low_i[39:32];
  assign c4   = pres_low_i[47:40];
  assign c5   = pres_low_i[63:48];
  assign c6   = pres_high_i[15:0];
  assign c7   = pres_high_i[23:16];
  assign c8   = pres_high_i[31:24];
  assign c9   = pres_high_i[47:32];
  assign c10  = pres_high_i[55:48];
  assign c11  = pres_high_i[63:56];
  assign c1m  = {{2{c1[15]}}, c1} - 18'sd16384;
  assign c2m  = {{2{c2[15]}}, c2} - 18'sd16384;

  logic signed [63:0] a64;
  logic signed [25:0] b26;
  logic signed [31:0] a32;
  logic signed [57:0] m;
  logic signed [63:0] m64;

  always_comb begin
    case (cmd_i.a_sel)
      baro_pkg::A_X:   a64 = {{39{x_q[24]}}, x_q};
      baro_pkg::A_T:   a64 = {{43{t_q[20]}}, t_q};
      baro_pkg::A_T2:  a64 = {{24{t2_q[39]}}, t2_q};
      baro_pkg::A_T3S: a64 = {{16{t3s_q[47]}}, t3s_q};
      baro_pkg::A_R2S: a64 = {{31{r2s_q[32]}}, r2s_q};
      baro_pkg::A_R3:  a64 = {{7{r3_q[56]}}, r3_q};
      baro_pkg::A_U:   a64 = {{14{u_q[49]}}, u_q};
      baro_pkg::A_S:   a64 = {{24{s_q[39]}}, s_q};
      default:         a64 = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.b_sel)
      baro_pkg::B_X:   b26 = {x_q[24], x_q};
      baro_pkg::B_T:   b26 = {{5{t_q[20]}}, t_q};
      baro_pkg::B_T2C: b26 = {10'b0, c_t2};
      baro_pkg::B_T3C: b26 = {{18{c_t3[7]}}, c_t3};
      baro_pkg::B_C2M: b26 = {{8{c2m[17]}}, c2m};
      baro_pkg::B_C3:  b26 = {{18{c3[7]}}, c3};
      baro_pkg::B_C4:  b26 = {{18{c4[7]}}, c4};
      baro_pkg::B_C6:  b26 = {10'b0, c6};
      baro_pkg::B_C7:  b26 = {{18{c7[7]}}, c7};
      baro_pkg::B_C8:  b26 = {{18{c8[7]}}, c8};
      baro_pkg::B_C9:  b26 = {{10{c9[15]}}, c9};
      baro_pkg::B_C10: b26 = {{18{c10[7]}}, c10};
      baro_pkg::B_C11: b26 = {{18{c11[7]}}, c11};
      default:         b26 = '0;
    endcase
  end

  // The low pass takes bits 30:0 as an unsigned value, the high pass the signed rest.
  always_comb begin
    case (cmd_i.mul)
      baro_pkg::MUL_LO: a32 = {1'b0, a64[30:0]};
      baro_pkg::MUL_HI: a32 = a64[62:31];
      default:          a32 = a64[31:0];
    endcase
  end

  assign m   = a32 * b26;
  assign m64 = {{6{m[57]}}, m};

  always_comb begin
    case (cmd_i.mul)
      baro_pkg::MUL_FULL: prod_d = m64;
      baro_pkg::MUL_LO:   prod_d = m64;
      baro_pkg::MUL_HI:   prod_d = prod_q + (m64 <<< 31);
      default:            prod_d = prod_q;
    endcase
  end

  logic signed [63:0] sh;
  assign sh = (prod_q <<< cmd_i.shl) >>> cmd_i.shr;

  // Final rounding and clamp to the 32-bit result range.
  logic signed [63:0] rnd;
  logic               fits;
  logic signed [31:0] res;
  assign rnd  = (kind_q == baro_pkg::KIND_PRES) ? ((acc_q + baro_pkg::RND_PRES) >>> 16)
                                                : ((acc_q + baro_pkg::RND_TEMP) >>> 40);
  assign fits = (&rnd[63:31]) | ~(|rnd[63:31]);
  always_comb begin
    if (fits) begin
      res = rnd[31:0];
    end else if (rnd[63]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q <= baro_pkg::T_RESET;
    end else if (cmd_i.fin && kind_q == baro_pkg::KIND_TEMP) begin
      t_q <= res[20:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load) begin
      kind_q <= req_type_i;
      x_q    <= req_type_i ? {1'b0, raw_sample_i} : ({1'b0, raw_sample_i} - {1'b0, c_t1, 8'b0});
      acc_q  <= {29'b0, c5, 19'b0};
      s_q    <= {{22{c1m[17]}}, c1m} <<< 10;
    end else begin
      case (cmd_i.wb)
        baro_pkg::WB_ACC_SET: acc_q <= sh;
        baro_pkg::WB_ACC_ADD: acc_q <= acc_q + sh;
        baro_pkg::WB_S_ADD:   s_q   <= s_q + sh[39:0];
        baro_pkg::WB_T2:      t2_q  <= sh[39:0];
        baro_pkg::WB_T3S:     t3s_q <= sh[47:0];
        baro_pkg::WB_R2S:     r2s_q <= sh[32:0];
        baro_pkg::WB_R3:      r3_q  <= sh[56:0];
        baro_pkg::WB_U:       u_q   <= sh[49:0];
        default: ;
      endcase
    end
    if (cmd_i.fin) begin
      result_kind_o <= kind_q;
      value_o       <= res;
      saturated_o   <= ~fits;
    end
  end

  assign kind_o = kind_q;

endmodule

@@ rtl/baro_ctrl.sv @@
`timescale 1ns / 1ps

module baro_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  logic           kind_i,
  output baro_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [baro_pkg::STEP_W-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic accept, slot_free, done;
  baro_pkg::cmd_t pcmd;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign pcmd       = baro_pkg::prog_cmd(kind_i, step_q);
  assign done       = (state_q == S_RUN) && pcmd.fin && slot_free;

  always_comb begin
    cmd_o      = pcmd;
    cmd_o.load = 1'b0;
    cmd_o.fin  = done;
    if (state_q != S_RUN) begin
      cmd_o.mul  = baro_pkg::MUL_NONE;
      cmd_o.wb   = baro_pkg::WB_NONE;
      cmd_o.load = accept;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          step_d  = '0;
        end
      end
      S_RUN: begin
        if (done) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end else if (!pcmd.fin) begin
          step_d = step_q + 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RUN) && (step_q == '0))
    else $error("accepted item did not start the sequence");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (step_q <= baro_pkg::LAST_PRES_STEP))
    else $error("step counter ran past the program");

  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RUN))
    else $error("result appeared without a finished sequence");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> slot_free)
    else $error("result register overwritten while held");

endmodule

@@ rtl/barometer_compensation.sv @@
// Barometric temperature and pressure compensation with sensor trim.
// Input channel: in_valid_i / in_stall_o carry req_type_i (0 temperature,
// 1 pressure) and a 24-bit raw reading. Output channel: out_valid_o /
// out_stall_i carry result_kind_o, value_o (1/256 degC or Pa) and
// saturated_o. Trim coefficients are written over the APB port at byte
// addresses 0, 8 and 16; the user must write them only while the block is
// idle, which the block itself does not enforce. One item is worked at a
// time on a shared 32x26-bit multiplier under a microprogram. A result is
// registered when the sequence reaches its final step; the next item is
// accepted only after the result is registered and the block is idle.
// A finished result sits in the output register; if it is still stalled when
// the next item completes, the sequencer holds on its last step.
// A temperature result is kept and used by later pressure items.
// Reset clears the trim registers, empties the output and sets the kept
// temperature to 15 degC.
`timescale 1ns / 1ps

module barometer_compensation (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [23:0]       raw_sample_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic signed [31:0] value_o,
  output logic              saturated_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [39:0] temp_trim_q;
  logic [63:0] pres_low_q;
  logic [63:0] pres_high_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q <= '0;
      pres_low_q  <= '0;
      pres_high_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        baro_pkg::REG_TEMP_TRIM: temp_trim_q <= pwdata[39:0];
        baro_pkg::REG_PRES_LOW:  pres_low_q  <= pwdata;
        baro_pkg::REG_PRES_HIGH: pres_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      baro_pkg::REG_TEMP_TRIM: prdata = {24'b0, temp_trim_q};
      baro_pkg::REG_PRES_LOW:  prdata = pres_low_q;
      baro_pkg::REG_PRES_HIGH: prdata = pres_high_q;
      default:                 prdata = '0;
    endcase
  end

  baro_pkg::cmd_t cmd;
  logic           kind;

  baro_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_i      (kind),
    .cmd_o       (cmd)
  );

  baro_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .raw_sample_i  (raw_sample_i),
    .temp_trim_i   (temp_trim_q),
    .pres_low_i    (pres_low_q),
    .pres_high_i   (pres_high_q),
    .kind_o        (kind),
    .result_kind_o (result_kind_o),
    .value_o       (value_o),
    .saturated_o   (saturated_o)
  );

endmodule
